// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MRR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("lbl");
`define MRR_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("lbl");
`else
`define MRR_ASSERT(lbl, clk, rst_n, prop)
`define MRR_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: rtl/core/mrr_pkg.sv
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared widths and types for the Miller-Rabin round.
// ----------------------------------------------------------------------------
package mrr_pkg;
  localparam int VALUE_BITS = 32;
  localparam int NW         = VALUE_BITS - 1;      // magnitude of a positive n
  localparam int DRAW_W     = 31;
  localparam int DCNT_W     = $clog2(DRAW_W);
  localparam int MCNT_W     = $clog2(NW + 1);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic              trivial;
    logic              verdict;
    logic [NW-1:0]     n;
    logic [DRAW_W-1:0] draw;
  } entry_t;

  typedef struct packed {
    logic          start;
    logic [NW-1:0] x;
    logic [NW-1:0] y;
  } mm_req_t;
endpackage

// File: rtl/core/miller_rabin_round.sv
// ----------------------------------------------------------------------------
// miller_rabin_round
// One Miller-Rabin round: a classifier, a two-entry queue and a test engine.
// ----------------------------------------------------------------------------
// Trivial candidates (n <= 3, n == 4, negative, even) are answered from the
// queue while the engine is idle. Odd n >= 5: witness reduction, odd-part
// split, then modular multiplies in the bit-serial unit; at most 60
// multiplies (a square and a multiply per odd-part bit) for a 31-bit n.
// Throughput: one transaction at a time in the engine; busy_o rises when the
// queue holds two. Reset clears all control state; the receiver cannot stall.
// ----------------------------------------------------------------------------
module miller_rabin_round (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] candidate_i,
  input  logic [30:0] random_draw_i,
  output logic        busy_o,
  output logic        result_valid_o,
  output logic        probably_prime_o
);
  mrr_pkg::entry_t front_entry, head;
  logic            q_empty, q_full, pop;

  // Classify combinationally; the queue entry carries the early verdict.
  mrr_front u_front (
    .candidate_i   (candidate_i),
    .random_draw_i (random_draw_i),
    .entry_o       (front_entry)
  );

  mrr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start_i && !q_full),
    .entry_i (front_entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Engine drains the queue in order, so verdicts leave in arrival order.
  mrr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .empty_i          (q_empty),
    .pop_o            (pop),
    .result_valid_o   (result_valid_o),
    .probably_prime_o (probably_prime_o)
  );

  assign busy_o = q_full;
endmodule

// File: rtl/core/mrr_front.sv
// ----------------------------------------------------------------------------
// mrr_front
// Classifies a candidate: settles small, negative and even values at once.
// ----------------------------------------------------------------------------
module mrr_front (
  input  logic [31:0]                   candidate_i,
  input  logic [mrr_pkg::DRAW_W-1:0]    random_draw_i,
  output mrr_pkg::entry_t               entry_o
);
  logic [mrr_pkg::VALUE_BITS-1:0] raw;
  logic [mrr_pkg::NW-1:0]         n;

  assign raw = candidate_i[mrr_pkg::VALUE_BITS-1:0];
  assign n   = raw[mrr_pkg::NW-1:0];

  always_comb begin
    entry_o.n       = n;
    entry_o.draw    = random_draw_i;
    entry_o.trivial = 1'b1;
    entry_o.verdict = 1'b0;
    if (raw[mrr_pkg::VALUE_BITS-1]) begin
      entry_o.verdict = 1'b0;
    end else if (n <= mrr_pkg::NW'(1) || n == mrr_pkg::NW'(4)) begin
      entry_o.verdict = 1'b0;
    end else if (n <= mrr_pkg::NW'(3)) begin
      entry_o.verdict = 1'b1;
    end else if (!n[0]) begin
      entry_o.verdict = 1'b0;
    end else begin
      entry_o.trivial = 1'b0;
    end
  end
endmodule

// File: rtl/core/mrr_queue.sv
// ----------------------------------------------------------------------------
// mrr_queue
// Two-entry FIFO between the classifier and the test engine.
// ----------------------------------------------------------------------------
module mrr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mrr_pkg::entry_t entry_i,
  input  logic            pop_i,
  output mrr_pkg::entry_t head_o,
  output logic            empty_o,
  output logic            full_o
);
  mrr_pkg::entry_t                mem_q [mrr_pkg::QDEPTH];
  logic [mrr_pkg::QPTR_W-1:0]     wptr_q, rptr_q;
  logic [mrr_pkg::QCNT_W-1:0]     cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == mrr_pkg::QCNT_W'(mrr_pkg::QDEPTH));
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= entry_i;
  end
endmodule

// File: rtl/core/mrr_modmul.sv
// ----------------------------------------------------------------------------
// mrr_modmul
// Bit-serial modular multiply x*y mod n, one bit of y per cycle.
// ----------------------------------------------------------------------------
module mrr_modmul (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mrr_pkg::mm_req_t       req_i,
  input  logic [mrr_pkg::NW-1:0] n_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [mrr_pkg::NW-1:0] p_o
);
  logic [mrr_pkg::NW-1:0]     acc_q, x_q, y_q;
  logic [mrr_pkg::MCNT_W-1:0] cnt_q;
  logic                       done_q;
  logic [mrr_pkg::NW:0]       t, t_r, u, u_r;

  // acc = 2*acc + bit*x, reduced after each step; both partials stay below 2n
  always_comb begin
    t   = {acc_q, 1'b0};
    t_r = (t >= {1'b0, n_i}) ? t - {1'b0, n_i} : t;
    u   = t_r + (y_q[mrr_pkg::NW-1] ? {1'b0, x_q} : '0);
    u_r = (u >= {1'b0, n_i}) ? u - {1'b0, n_i} : u;
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign p_o    = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= mrr_pkg::MCNT_W'(mrr_pkg::NW);
      end else if (busy_o) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == mrr_pkg::MCNT_W'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      x_q   <= req_i.x;
      y_q   <= req_i.y;
    end else if (busy_o) begin
      acc_q <= u_r[mrr_pkg::NW-1:0];
      y_q   <= {y_q[mrr_pkg::NW-2:0], 1'b0};
    end
  end
endmodule

// File: rtl/core/mrr_back.sv
// ----------------------------------------------------------------------------
// mrr_back
// Test engine: witness selection, odd-part split, power and squaring chain.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module mrr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mrr_pkg::entry_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            result_valid_o,
  output logic            probably_prime_o
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIV   = 8'b0000_0010,
    S_SPLIT = 8'b0000_0100,
    S_PSTEP = 8'b0000_1000,
    S_PMUL  = 8'b0001_0000,
    S_PSQ   = 8'b0010_0000,
    S_CHK   = 8'b0100_0000,
    S_SQW   = 8'b1000_0000
  } state_e;

  localparam int NW = mrr_pkg::NW;

  state_e                     state_q, state_d;
  logic [NW-1:0]              n_q, den_q, d_q, acc_q, base_q;
  logic [NW:0]                rem_q, rem_sh;
  logic [mrr_pkg::DRAW_W-1:0] draw_q;
  logic [mrr_pkg::DCNT_W-1:0] dcnt_q;
  logic [mrr_pkg::MCNT_W-1:0] r_q, i_q;
  logic                       vld_q, verdict_q;
  logic                       emit, emit_val;
  mrr_pkg::mm_req_t           mm_req;
  logic                       mm_busy, mm_done;
  logic [NW-1:0]              mm_p, nm1;

  mrr_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .n_i    (n_q),
    .busy_o (mm_busy),
    .done_o (mm_done),
    .p_o    (mm_p)
  );

  assign nm1    = n_q - 1'b1;
  assign rem_sh = {rem_q[NW-1:0], draw_q[mrr_pkg::DRAW_W-1]};

  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    emit       = 1'b0;
    emit_val   = 1'b0;
    mm_req     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (head_i.trivial) begin
            emit     = 1'b1;
            emit_val = head_i.verdict;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (dcnt_q == mrr_pkg::DCNT_W'(mrr_pkg::DRAW_W - 1)) state_d = S_SPLIT;
      end
      S_SPLIT: begin
        if (d_q[0]) state_d = S_PSTEP;
      end
      S_PSTEP: begin
        if (d_q == '0) begin
          state_d = S_CHK;
        end else if (d_q[0]) begin
          mm_req  = '{start: 1'b1, x: acc_q, y: base_q};
          state_d = S_PMUL;
        end else begin
          mm_req  = '{start: 1'b1, x: base_q, y: base_q};
          state_d = S_PSQ;
        end
      end
      S_PMUL: begin
        if (mm_done) begin
          mm_req  = '{start: 1'b1, x: base_q, y: base_q};
          state_d = S_PSQ;
        end
      end
      S_PSQ: begin
        if (mm_done) state_d = S_PSTEP;
      end
      S_CHK: begin
        if (acc_q == NW'(1) || acc_q == nm1) begin
          emit     = 1'b1;
          emit_val = 1'b1;
          state_d  = S_IDLE;
        end else if (i_q >= r_q) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end else begin
          mm_req  = '{start: 1'b1, x: acc_q, y: acc_q};
          state_d = S_SQW;
        end
      end
      S_SQW: begin
        if (mm_done) begin
          if (mm_p == NW'(1)) begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_CHK;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) verdict_q <= emit_val;
    unique case (state_q)
      S_IDLE: begin
        n_q    <= head_i.n;
        den_q  <= head_i.n - NW'(4);
        d_q    <= head_i.n - 1'b1;
        draw_q <= head_i.draw;
        rem_q  <= '0;
        dcnt_q <= '0;
        r_q    <= '0;
        i_q    <= mrr_pkg::MCNT_W'(1);
      end
      S_DIV: begin
        // restoring division of the draw by n-4, remainder only
        rem_q  <= (rem_sh >= {1'b0, den_q}) ? rem_sh - {1'b0, den_q} : rem_sh;
        draw_q <= {draw_q[mrr_pkg::DRAW_W-2:0], 1'b0};
        dcnt_q <= dcnt_q + 1'b1;
      end
      S_SPLIT: begin
        if (!d_q[0]) begin
          d_q <= d_q >> 1;
          r_q <= r_q + 1'b1;
        end else begin
          base_q <= rem_q[NW-1:0] + NW'(2);
          acc_q  <= NW'(1);
        end
      end
      S_PMUL: if (mm_done) acc_q <= mm_p;
      S_PSQ: begin
        if (mm_done) begin
          base_q <= mm_p;
          d_q    <= d_q >> 1;
        end
      end
      S_SQW: begin
        if (mm_done) begin
          acc_q <= mm_p;
          i_q   <= i_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign result_valid_o   = vld_q;
  assign probably_prime_o = verdict_q;

  `MRR_ASSERT(a_emit_to_idle, clk_i, rst_ni, emit |=> state_q == S_IDLE)
  `MRR_NEVER(a_mm_start_busy, clk_i, rst_ni, mm_req.start && mm_busy)
  `MRR_NEVER(a_pop_empty, clk_i, rst_ni, pop_o && empty_i)
endmodule
